### rtl/maximum_bipartite_matching_unit_defines.svh
// Assertion macros for the bipartite matching unit.
// No dependencies; included by the top level only.
`ifndef MAXIMUM_BIPARTITE_MATCHING_UNIT_DEFINES_SVH
`define MAXIMUM_BIPARTITE_MATCHING_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MBM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MBM_ASSERT(label, clk, rst_n, prop, msg)
`define MBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/mbm_pkg.sv
// Shared types and constants for the bipartite matching unit.
// No dependencies.
package mbm_pkg;
  localparam int MaxLeft  = 16;
  localparam int MaxRight = 16;
  localparam int VW = 5;                 // vertex field width
  localparam int LW = $clog2(MaxLeft + 1);
  localparam int RW = $clog2(MaxRight + 1);
  localparam int SW = $clog2(MaxLeft + 2);
  localparam logic [VW-1:0] NoVertex = '0;
  localparam logic [LW:0] FarLayer = '1; // one bit wider than any real layer

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdRun     = 1'b1;
  localparam logic [0:0] RegLeftCount  = 1'b0;
  localparam logic [0:0] RegRightCount = 1'b1;

  // clamp a written count into 1..max
  function automatic logic [VW-1:0] clamp_count(input logic [VW-1:0] x, input int unsigned mx);
    logic [VW-1:0] y;
    y = (x == '0) ? VW'(1) : x;
    if (32'(y) > mx) y = VW'(mx);
    return y;
  endfunction
endpackage

### rtl/maximum_bipartite_matching_unit.sv
// Hopcroft-Karp maximum bipartite matching unit; needs mbm_pkg and the defines header.
// Edge beat: taken only while idle, busy stays low, no result; one edge beat per cycle while idle.
// Run beat: each phase seeds every left vertex, then pops each queued vertex and scans
//   its right vertices, then picks free roots, tries right vertices, pushes, pops and flips
//   frames. After the last phase, L result beats on consecutive cycles.
// The receiver cannot stall. Reset (rst_ni low, async) clears graph and total; counts go to 16.
`include "maximum_bipartite_matching_unit_defines.svh"
module maximum_bipartite_matching_unit import mbm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          cmd_i,
  input  logic [VW-1:0] left_vertex_i,
  input  logic [VW-1:0] right_vertex_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [VW-1:0] cfg_data_i,
  output logic          result_valid_o,
  output logic [VW-1:0] vertex_index_o,
  output logic [VW-1:0] partner_o,
  output logic [VW-1:0] match_size_o,
  output logic          last_o
);
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StBInit  = 4'd2;
  localparam logic [3:0] StBPop   = 4'd3;
  localparam logic [3:0] StBScan  = 4'd4;
  localparam logic [3:0] StAPick  = 4'd5;
  localparam logic [3:0] StAScan  = 4'd6;
  localparam logic [3:0] StACommit = 4'd7;
  localparam logic [3:0] StEmit   = 4'd8;

  logic [3:0] state_q;
  logic [VW-1:0] left_count_q, right_count_q;
  logic [MaxRight-1:0] adj_q [MaxLeft+1];
  logic [VW-1:0] lp_q [MaxLeft+1];
  logic [VW-1:0] rp_q [MaxRight+1];
  logic [LW:0]   dist_q [MaxLeft+1];
  logic [VW-1:0] queue_q [MaxLeft+1];
  logic [VW-1:0] stk_u_q [MaxLeft+2];
  logic [VW-1:0] stk_v_q [MaxLeft+2];
  logic [VW-1:0] total_q;
  logic [VW-1:0] u_q, v_q, cnt_q;         // current left vertex, right scan, counter
  logic [VW-1:0] head_q, tail_q;
  logic [SW-1:0] top_q;

  // shared compare unit: edge present and layered partner test
  logic          edge_hit;
  logic [VW-1:0] w_cur;
  logic [LW:0]   du_plus;
  always_comb begin
    edge_hit = adj_q[u_q[LW-1:0]][v_q[$clog2(MaxRight)-1:0] - 1'b1];
    w_cur    = rp_q[v_q[RW-1:0]];
    du_plus  = dist_q[u_q[LW-1:0]] + 1'b1;
  end

  assign busy = (state_q != StIdle);
  wire accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_count_q  <= VW'(MaxLeft);
      right_count_q <= VW'(MaxRight);
      total_q <= '0;
      u_q <= '0;
      v_q <= '0;
      cnt_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      top_q <= '0;
      result_valid_o <= 1'b0;
      vertex_index_o <= '0;
      partner_o <= '0;
      match_size_o <= '0;
      last_o <= 1'b0;
      for (int i = 0; i <= MaxLeft; i++) begin
        adj_q[i] <= '0;
        lp_q[i] <= '0;
        dist_q[i] <= '0;
        queue_q[i] <= '0;
      end
      for (int i = 0; i <= MaxLeft + 1; i++) begin
        stk_u_q[i] <= '0;
        stk_v_q[i] <= '0;
      end
      for (int i = 0; i <= MaxRight; i++) rp_q[i] <= '0;
    end else begin
      // one result beat per emit cycle
      result_valid_o <= (state_q == StEmit);
      last_o <= (state_q == StEmit) && (cnt_q == left_count_q);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegLeftCount) left_count_q <= clamp_count(cfg_data_i, MaxLeft);
        else right_count_q <= clamp_count(cfg_data_i, MaxRight);
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (cmd_i == CmdAddEdge) begin
              // drop out-of-range edges, merge duplicates
              if (left_vertex_i >= VW'(1) && left_vertex_i <= left_count_q &&
                  right_vertex_i >= VW'(1) && right_vertex_i <= right_count_q)
                adj_q[left_vertex_i[LW-1:0]][right_vertex_i[$clog2(MaxRight)-1:0] - 1'b1]
                  <= 1'b1;
            end else begin
              for (int i = 0; i <= MaxLeft; i++) lp_q[i] <= '0;
              for (int i = 0; i <= MaxRight; i++) rp_q[i] <= '0;
              total_q <= '0;
              u_q <= VW'(1);
              tail_q <= '0;
              state_q <= StBInit;
            end
          end
        end
        StBInit: begin
          // seed layer 0 with free left vertices, one row per cycle
          if (u_q > left_count_q) begin
            dist_q[0] <= FarLayer;
            head_q <= '0;
            state_q <= StBPop;
          end else begin
            if (lp_q[u_q[LW-1:0]] == NoVertex) begin
              dist_q[u_q[LW-1:0]] <= '0;
              queue_q[tail_q[LW-1:0]] <= u_q;
              tail_q <= tail_q + 1'b1;
            end else dist_q[u_q[LW-1:0]] <= FarLayer;
            u_q <= u_q + 1'b1;
          end
        end
        StBPop: begin
          if (head_q < tail_q) begin
            u_q <= queue_q[head_q[LW-1:0]];
            head_q <= head_q + 1'b1;
            v_q <= VW'(1);
            state_q <= StBScan;
          end else if (dist_q[0] != FarLayer) begin
            u_q <= VW'(1);
            state_q <= StAPick;
          end else begin
            cnt_q <= VW'(1);
            state_q <= StEmit;
          end
        end
        StBScan: begin
          if (dist_q[u_q[LW-1:0]] >= dist_q[0] || v_q > right_count_q) state_q <= StBPop;
          else begin
            if (edge_hit && dist_q[w_cur[LW-1:0]] == FarLayer) begin
              dist_q[w_cur[LW-1:0]] <= du_plus;
              if (w_cur != NoVertex) begin
                queue_q[tail_q[LW-1:0]] <= w_cur;
                tail_q <= tail_q + 1'b1;
              end
            end
            v_q <= v_q + 1'b1;
          end
        end
        StAPick: begin
          // cnt_q takes the root left vertex of the next search
          if (u_q > left_count_q) begin
            u_q <= VW'(1);
            tail_q <= '0;
            state_q <= StBInit;
          end else if (lp_q[u_q[LW-1:0]] == NoVertex) begin
            cnt_q <= u_q;
            top_q <= '0;
            stk_u_q[0] <= u_q;
            v_q <= VW'(1);
            state_q <= StAScan;
          end else u_q <= u_q + 1'b1;
        end
        StAScan: begin
          // u_q tracks the vertex of the top frame
          if (v_q > right_count_q) begin
            // dead end: retire vertex, pop a frame or, at the root, go back to picking
            dist_q[stk_u_q[top_q][LW-1:0]] <= FarLayer;
            if (top_q == '0) begin
              u_q <= cnt_q + 1'b1;
              state_q <= StAPick;
            end else begin
              top_q <= top_q - 1'b1;
              u_q <= stk_u_q[top_q - 1'b1];
              v_q <= stk_v_q[top_q - 1'b1] + 1'b1;
            end
          end else if (edge_hit && dist_q[w_cur[LW-1:0]] == du_plus) begin
            stk_v_q[top_q] <= v_q;
            if (w_cur == NoVertex) state_q <= StACommit;
            else begin
              top_q <= top_q + 1'b1;
              stk_u_q[top_q + 1'b1] <= w_cur;
              u_q <= w_cur;
              v_q <= VW'(1);
            end
          end else v_q <= v_q + 1'b1;
        end
        StACommit: begin
          // flip one frame per cycle, top down
          lp_q[stk_u_q[top_q][LW-1:0]] <= stk_v_q[top_q];
          rp_q[stk_v_q[top_q][RW-1:0]] <= stk_u_q[top_q];
          if (top_q == '0) begin
            total_q <= total_q + 1'b1;
            u_q <= cnt_q + 1'b1;
            state_q <= StAPick;
          end else top_q <= top_q - 1'b1;
        end
        StEmit: begin
          vertex_index_o <= cnt_q;
          partner_o <= lp_q[cnt_q[LW-1:0]];
          match_size_o <= total_q;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == left_count_q) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `MBM_ASSERT(a_emit_only, clk_i, rst_ni, !result_valid_o || state_q == StEmit || last_o, "beat")
  `MBM_ASSERT(a_last_idle, clk_i, rst_ni, !(result_valid_o && last_o) || !busy, "busy on last")
  `MBM_ASSERT_NEXT(a_run_busy, clk_i, rst_ni, accept && cmd_i == CmdRun, busy, "run not started")
  `MBM_ASSERT(a_size_cap, clk_i, rst_ni, total_q <= VW'(MaxLeft), "size above max")
endmodule

### tb/tb.sv
// Self-checking testbench for the Hopcroft-Karp bipartite matching unit.
// Depends on mbm_pkg and the unit's RTL; loads random graphs and checks every run.
module tb;
  import mbm_pkg::*;

  typedef struct packed {
    logic          cmd;
    logic [VW-1:0] lv;
    logic [VW-1:0] rv;
  } job_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] partner;
    logic [VW-1:0] size;
    logic          last;
  } match_row_t;

  localparam int CycleLimit = 3000000;
  localparam int FarL = 32'hFFFF;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic          cmd_i = 1'b0;
  logic [VW-1:0] left_vertex_i = '0;
  logic [VW-1:0] right_vertex_i = '0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = 1'b0;
  logic [VW-1:0] cfg_data_i = '0;
  logic          result_valid_o;
  logic [VW-1:0] vertex_index_o;
  logic [VW-1:0] partner_o;
  logic [VW-1:0] match_size_o;
  logic          last_o;

  maximum_bipartite_matching_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .left_vertex_i, .right_vertex_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .result_valid_o, .vertex_index_o,
    .partner_o, .match_size_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the graph and the counts.
  logic [MaxRight-1:0] graph_rows [MaxLeft+1];
  int                  n_left = MaxLeft;
  int                  n_right = MaxRight;
  int                  mate_l [MaxLeft+1];
  int                  mate_r [MaxRight+1];
  int                  layer_of [MaxLeft+1];
  job_t                pending_jobs [$];
  match_row_t          expected_rows [$];
  int                  errors = 0;
  int                  cycles = 0;
  bit                  quiet = 1'b0;   // suppress sender gaps
  bit                  hold = 1'b0;    // sender paused by the sequencer

  function automatic bit edge_at(int u, int v);
    return graph_rows[u][v-1];
  endfunction

  function automatic bit layer_graph();
    int q [$];
    int u, w;
    for (u = 1; u <= n_left; u++) begin
      if (mate_l[u] == 0) begin
        layer_of[u] = 0;
        q = {q, u};
      end else layer_of[u] = FarL;
    end
    layer_of[0] = FarL;
    while (q.size() > 0) begin
      u = q.pop_front();
      if (layer_of[u] >= layer_of[0]) continue;
      for (int v = 1; v <= n_right; v++) begin
        if (!edge_at(u, v)) continue;
        w = mate_r[v];
        if (layer_of[w] == FarL) begin
          layer_of[w] = layer_of[u] + 1;
          if (w != 0) q = {q, w};
        end
      end
    end
    return layer_of[0] != FarL;
  endfunction

  function automatic bit grow_path(int root);
    int sv [MaxLeft+2];
    int sp [MaxLeft+2];
    int top, u, v, w;
    top = 0;
    sv[0] = root;
    sp[0] = 1;
    forever begin
      u = sv[top];
      for (v = sp[top]; v <= n_right; v++)
        if (edge_at(u, v) && layer_of[mate_r[v]] == layer_of[u] + 1) break;
      if (v > n_right) begin
        layer_of[u] = FarL;
        if (top == 0) return 1'b0;
        top--;
        sp[top]++;
        continue;
      end
      sp[top] = v;
      w = mate_r[v];
      if (w == 0) begin
        for (int k = top; k >= 0; k--) begin
          mate_r[sp[k]] = sv[k];
          mate_l[sv[k]] = sp[k];
        end
        return 1'b1;
      end
      if (top + 1 >= MaxLeft + 2) return 1'b0;
      top++;
      sv[top] = w;
      sp[top] = 1;
    end
  endfunction

  // Apply one accepted beat to the predictor; a run queues its rows.
  function automatic void predict_matching(job_t j);
    int total;
    match_row_t r;
    if (j.cmd == CmdAddEdge) begin
      if (j.lv >= 1 && j.lv <= n_left && j.rv >= 1 && j.rv <= n_right)
        graph_rows[j.lv][j.rv-1] = 1'b1;
      return;
    end
    total = 0;
    for (int i = 0; i <= MaxLeft; i++) mate_l[i] = 0;
    for (int i = 0; i <= MaxRight; i++) mate_r[i] = 0;
    while (layer_graph())
      for (int u = 1; u <= n_left; u++)
        if (mate_l[u] == 0 && grow_path(u)) total++;
    for (int u = 1; u <= n_left; u++) begin
      r.vertex = VW'(u);
      r.partner = VW'(mate_l[u]);
      r.size = VW'(total);
      r.last = (u == n_left);
      expected_rows = {expected_rows, r};
    end
  endfunction

  function automatic void set_count(logic idx, logic [VW-1:0] val);
    int x;
    x = (val == 0) ? 1 : int'(val);
    if (idx == RegLeftCount) n_left = (x > MaxLeft) ? MaxLeft : x;
    else n_right = (x > MaxRight) ? MaxRight : x;
  endfunction

  // Driver: offer the head job until accepted; gaps and hold may drop start meanwhile.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_matching('{cmd: cmd_i, lv: left_vertex_i, rv: right_vertex_i});
        void'(pending_jobs.pop_front());
      end
      if (hold || pending_jobs.size() == 0 || (!quiet && $urandom_range(99) < 9)) begin
        start <= 1'b0;
      end else begin
        job_t nx;
        nx = pending_jobs[0];
        start <= 1'b1;
        cmd_i <= nx.cmd;
        left_vertex_i <= nx.lv;
        right_vertex_i <= nx.rv;
      end
    end
  end

  // Monitor: compare each result beat against the oldest expected row.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result beat vertex_index=%0d", vertex_index_o);
        errors++;
      end else begin
        match_row_t e;
        e = expected_rows.pop_front();
        if (vertex_index_o !== e.vertex) begin
          $error("vertex_index expected %0d actual %0d", e.vertex, vertex_index_o);
          errors++;
        end
        if (partner_o !== e.partner) begin
          $error("partner expected %0d actual %0d", e.partner, partner_o);
          errors++;
        end
        if (match_size_o !== e.size) begin
          $error("match_size expected %0d actual %0d", e.size, match_size_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("maximum_bipartite_matching_unit verification failed");
      $finish;
    end
  end

  // Wait until every queued job is accepted and all rows are back.
  task automatic drain();
    while (pending_jobs.size() > 0 || start) @(posedge clk_i);
    while (busy || expected_rows.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(logic idx, logic [VW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    set_count(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_job(logic c, int l, int r);
    job_t j;
    j = '{cmd: c, lv: VW'(l), rv: VW'(r)};
    pending_jobs = {pending_jobs, j};
  endfunction

  // One random graph followed by a run; density picks sparse or dense graphs.
  function automatic void random_graph(int n_edges);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(19) == 0) add_job(CmdAddEdge, $urandom_range(31), $urandom_range(31));
      else add_job(CmdAddEdge, $urandom_range(n_left, 1), $urandom_range(n_right, 1));
    end
    add_job(CmdRun, $urandom_range(31), $urandom_range(31));
  endfunction

  initial begin
    int sent;
    for (int i = 0; i <= MaxLeft; i++) graph_rows[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: run on empty graph, extremes, out-of-range and duplicate edges.
    add_job(CmdRun, 0, 0);
    add_job(CmdAddEdge, 1, 1);
    add_job(CmdAddEdge, 1, 1);
    add_job(CmdAddEdge, 16, 16);
    add_job(CmdAddEdge, 0, 3);
    add_job(CmdAddEdge, 3, 0);
    add_job(CmdAddEdge, 17, 2);
    add_job(CmdAddEdge, 31, 31);
    add_job(CmdAddEdge, 2, 1);
    add_job(CmdAddEdge, 2, 16);
    add_job(CmdAddEdge, 16, 1);
    add_job(CmdRun, 31, 31);
    drain();
    // Shrink counts below loaded edges; zero acts as one.
    write_count(RegLeftCount, 5'd0);
    write_count(RegRightCount, 5'd2);
    add_job(CmdRun, 0, 0);
    drain();
    write_count(RegLeftCount, 5'd31);
    write_count(RegRightCount, 5'd0);
    add_job(CmdAddEdge, 5, 1);
    add_job(CmdAddEdge, 5, 2);
    add_job(CmdRun, 0, 0);
    drain();
    write_count(RegRightCount, 5'd20);
    add_job(CmdRun, 0, 0);
    drain();
    // Random phases: new counts each phase, no gaps in some.
    sent = 0;
    while (sent < 400) begin
      int ne;
      write_count(RegLeftCount, $urandom_range(3) == 0 ? 5'(MaxLeft) : 5'($urandom_range(31)));
      write_count(RegRightCount, $urandom_range(3) == 0 ? 5'(MaxRight) : 5'($urandom_range(31)));
      quiet = ($urandom_range(4) == 0);
      for (int g = 0; g < 3; g++) begin
        ne = $urandom_range(24, 2);
        random_graph(ne);
        sent += ne + 1;
      end
      if (sent > 200 && sent < 260) begin
        // Pause the sender until all outstanding rows are back.
        hold = 1'b1;
        while (busy || expected_rows.size() > 0) @(posedge clk_i);
        hold = 1'b0;
      end
      drain();
      quiet = 1'b0;
    end
    drain();
    if (errors == 0) $display("maximum_bipartite_matching_unit verification clean");
    else $display("maximum_bipartite_matching_unit verification failed");
    $finish;
  end
endmodule
